/* src/hsvrgb_pkg.sv */
// Shared types, constants and scaling helper for the rainbow HSV to RGB converter.
`default_nettype none

package hsvrgb_pkg;

    localparam int unsigned CHAN_W = 8;

    // Ramp and band levels
    localparam logic [CHAN_W-1:0] LVL_FULL  = 8'd255;
    localparam logic [CHAN_W-1:0] LVL_THIRD = 8'd85;
    localparam logic [CHAN_W-1:0] LVL_2TH   = 8'd170;
    localparam logic [CHAN_W-1:0] LVL_2TH_R = 8'd171;
    localparam logic [CHAN_W-1:0] LVL_ZERO  = 8'd0;

    // Rainbow bands picked by the top three hue bits
    typedef enum logic [2:0] {
        BAND_RED_ORANGE    = 3'd0,
        BAND_ORANGE_YELLOW = 3'd1,
        BAND_YELLOW_GREEN  = 3'd2,
        BAND_GREEN_CYAN    = 3'd3,
        BAND_CYAN_BLUE     = 3'd4,
        BAND_BLUE_PURPLE   = 3'd5,
        BAND_PURPLE_MAG    = 3'd6,
        BAND_MAG_RED       = 3'd7
    } t_band;

    typedef struct packed {
        logic [CHAN_W-1:0] hue_in;
        logic [CHAN_W-1:0] saturation_in;
        logic [CHAN_W-1:0] value_in;
    } t_hsv;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
    } t_rgb;

    // Video-style scale: zero stays zero, otherwise keep one LSB of light
    function automatic logic [CHAN_W-1:0] vid_scale(
        input logic [CHAN_W-1:0] x,
        input logic [CHAN_W-1:0] f
    );
        logic [2*CHAN_W-1:0] prod;
        prod = {{CHAN_W{1'b0}}, x} * {{CHAN_W{1'b0}}, f};
        if ((x == LVL_ZERO) || (f == LVL_ZERO)) begin
            return LVL_ZERO;
        end
        return prod[2*CHAN_W-1:CHAN_W] + 8'd1;
    endfunction

endpackage

`default_nettype wire

/* src/hsvrgb_hue_map.sv */
// Rainbow hue band mapping: hue byte to unscaled RGB triple.
`default_nettype none

module hsvrgb_hue_map
    import hsvrgb_pkg::*;
(
    input  wire logic [CHAN_W-1:0] i_hue,
    output t_rgb                   o_rgb
);

    logic [CHAN_W-1:0]   pos8;
    logic [2*CHAN_W-1:0] prod1;
    logic [2*CHAN_W-1:0] prod2;
    logic [CHAN_W-1:0]   t1;
    logic [CHAN_W-1:0]   t2;
    t_band               band;

    // Ramp position times 8, then third and two-thirds of it
    assign pos8  = {i_hue[4:0], 3'b000};
    assign prod1 = {{CHAN_W{1'b0}}, pos8} * {{CHAN_W{1'b0}}, LVL_THIRD};
    assign prod2 = {{CHAN_W{1'b0}}, pos8} * {{CHAN_W{1'b0}}, LVL_2TH};
    assign t1    = prod1[2*CHAN_W-1:CHAN_W];
    assign t2    = prod2[2*CHAN_W-1:CHAN_W];
    assign band  = t_band'(i_hue[7:5]);

    // Band select; all terms stay inside 0..255 for any ramp position
    always_comb begin
        case (band)
            BAND_RED_ORANGE: begin
                o_rgb = '{LVL_FULL - t1, t1, LVL_ZERO};
            end
            BAND_ORANGE_YELLOW: begin
                o_rgb = '{LVL_2TH_R, LVL_THIRD + t1, LVL_ZERO};
            end
            BAND_YELLOW_GREEN: begin
                o_rgb = '{LVL_2TH_R - t2, LVL_2TH + t1, LVL_ZERO};
            end
            BAND_GREEN_CYAN: begin
                o_rgb = '{LVL_ZERO, LVL_FULL - t1, t1};
            end
            BAND_CYAN_BLUE: begin
                o_rgb = '{LVL_ZERO, LVL_2TH_R - t2, LVL_THIRD + t2};
            end
            BAND_BLUE_PURPLE: begin
                o_rgb = '{t1, LVL_ZERO, LVL_FULL - t1};
            end
            BAND_PURPLE_MAG: begin
                o_rgb = '{LVL_THIRD + t1, LVL_ZERO, LVL_2TH_R - t1};
            end
            default: begin
                o_rgb = '{LVL_2TH + t1, LVL_ZERO, LVL_THIRD - t1};
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/hsv_to_rgb_rainbow_converter_unit.sv */
// Top level: three-stage pipelined rainbow HSV to RGB converter.
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+---------------------
//   input   | i_in_valid  | o_in_stall  | i_in_data  (t_hsv)
//   output  | o_out_valid | i_out_stall | o_out_data (t_rgb)
//
// One pixel per clock while the output is not stalled; a result passes the
// stage 1, stage 2 and stage 3 registers before it shows at the output.
// Stage 1: hue band map and saturation floor multiply. Stage 2: saturation
// scale (three 8x8 multiplies). Stage 3: value scale (three 8x8 multiplies).
// Each stage has its own valid bit and loads when empty or when the next one
// moves, so bubbles collapse under output stall. Reset clears the valid bits.
`default_nettype none

module hsv_to_rgb_rainbow_converter_unit
    import hsvrgb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_hsv i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_rgb      o_out_data
);

    // Stage valid bits and per-stage load enables
    logic r_v1, r_v2, r_v3;
    logic ld1, ld2, ld3;

    assign ld3 = !r_v3 || !i_out_stall;
    assign ld2 = !r_v2 || ld3;
    assign ld1 = !r_v1 || ld2;

    assign o_in_stall  = !ld1;
    assign o_out_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ld1) begin
                r_v1 <= i_in_valid;
            end
            if (ld2) begin
                r_v2 <= r_v1;
            end
            if (ld3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Stage 1: band map and desaturation floor
    t_rgb              hue_rgb;
    logic [CHAN_W-1:0] sat_inv;
    t_rgb              r_rgb1;
    logic [CHAN_W-1:0] r_floor1;
    logic [CHAN_W-1:0] r_sat1;
    logic [CHAN_W-1:0] r_val1;

    hsvrgb_hue_map u_hue_map (
        .i_hue (i_in_data.hue_in),
        .o_rgb (hue_rgb)
    );

    assign sat_inv = ~i_in_data.saturation_in;

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_rgb1   <= hue_rgb;
            r_floor1 <= vid_scale(sat_inv, sat_inv);
            r_sat1   <= i_in_data.saturation_in;
            r_val1   <= i_in_data.value_in;
        end
    end

    // Stage 2: saturation scale plus floor, clipped at full scale
    logic [CHAN_W-1:0] factor;
    logic [CHAN_W:0]   sum_r, sum_g, sum_b;
    t_rgb              n_rgb2;
    t_rgb              r_rgb2;
    logic [CHAN_W-1:0] r_val2;

    assign factor = LVL_FULL - r_floor1;
    assign sum_r  = {1'b0, vid_scale(r_rgb1.red_out,   factor)} + {1'b0, r_floor1};
    assign sum_g  = {1'b0, vid_scale(r_rgb1.green_out, factor)} + {1'b0, r_floor1};
    assign sum_b  = {1'b0, vid_scale(r_rgb1.blue_out,  factor)} + {1'b0, r_floor1};

    always_comb begin
        if (r_sat1 == LVL_FULL) begin
            n_rgb2 = r_rgb1;
        end else if (r_sat1 == LVL_ZERO) begin
            n_rgb2 = '{LVL_FULL, LVL_FULL, LVL_FULL};
        end else begin
            n_rgb2.red_out   = sum_r[CHAN_W] ? LVL_FULL : sum_r[CHAN_W-1:0];
            n_rgb2.green_out = sum_g[CHAN_W] ? LVL_FULL : sum_g[CHAN_W-1:0];
            n_rgb2.blue_out  = sum_b[CHAN_W] ? LVL_FULL : sum_b[CHAN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld2) begin
            r_rgb2 <= n_rgb2;
            r_val2 <= r_val1;
        end
    end

    // Stage 3: value scale; zero value falls out of vid_scale as black
    t_rgb n_rgb3;
    t_rgb r_rgb3;

    always_comb begin
        if (r_val2 == LVL_FULL) begin
            n_rgb3 = r_rgb2;
        end else begin
            n_rgb3.red_out   = vid_scale(r_rgb2.red_out,   r_val2);
            n_rgb3.green_out = vid_scale(r_rgb2.green_out, r_val2);
            n_rgb3.blue_out  = vid_scale(r_rgb2.blue_out,  r_val2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld3) begin
            r_rgb3 <= n_rgb3;
        end
    end

    assign o_out_data = r_rgb3;

endmodule

`default_nettype wire

/* src/hsvrgb_checker.sv */
// Port-level checker for the converter, bound to the top level.
`default_nettype none

module hsvrgb_checker
    import hsvrgb_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_stall,
    input wire t_hsv i_in_data,
    input wire logic o_out_valid,
    input wire logic i_out_stall,
    input wire t_rgb o_out_data
);

    logic in_xfer;
    assign in_xfer = i_in_valid && !o_in_stall;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Zero value gives black at the output when nothing stalls
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_in_data.value_in == LVL_ZERO) ##1 !i_out_stall ##1 !i_out_stall
        |=> o_out_valid && (o_out_data == '0))
        else $error("zero value did not give black");

    // Zero saturation at full value gives white
    a_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_in_data.saturation_in == LVL_ZERO)
            && (i_in_data.value_in == LVL_FULL)
            ##1 !i_out_stall ##1 !i_out_stall
        |=> o_out_valid && (o_out_data == '1))
        else $error("zero saturation did not give white");

endmodule

bind hsv_to_rgb_rainbow_converter_unit hsvrgb_checker u_hsvrgb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
